[rtl/nmea_cls_pkg.sv]
package nmea_cls_pkg;

  // Sentence buffer depth and the index width that can also hold the depth itself
  localparam int unsigned BufferSize = 128;
  localparam int unsigned IdxW       = $clog2(BufferSize + 1);

  // Field widths
  localparam int unsigned NumKinds = 19;
  localparam int unsigned KindW    = 5;
  localparam int unsigned CodeW    = 24;
  localparam int unsigned WIdxW    = 7;
  localparam int unsigned TmoW     = 16;

  // Characters that steer the parser
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChG      = 8'h47;
  localparam logic [7:0] ChP      = 8'h50;

  localparam logic [TmoW-1:0] TimeoutRst = 16'd1000;

  // Packed three-letter talker codes, in type-number order:
  // BOD BWC GGA GLL GSA GSV HDT R00 RMA RMB RMC RTE TRF STN VBW VTG WPL XTE ZDA
  localparam logic [CodeW-1:0] KindCodes [NumKinds] = '{
    24'd4345668, 24'd4347715, 24'd4671297, 24'd4672588, 24'd4674369,
    24'd4674390, 24'd4736084, 24'd5386288, 24'd5393729, 24'd5393730,
    24'd5393731, 24'd5395525, 24'd5526086, 24'd5461070, 24'd5653079,
    24'd5657671, 24'd5722188, 24'd5788741, 24'd5915713
  };

  // Parser phases
  typedef enum logic [6:0] {
    PhIdle  = 7'b0000001,
    PhWaitG = 7'b0000010,
    PhWaitP = 7'b0000100,
    PhCode1 = 7'b0001000,
    PhCode2 = 7'b0010000,
    PhCode3 = 7'b0100000,
    PhStore = 7'b1000000
  } phase_e;

  // Lookup result of the talker code table
  typedef struct packed {
    logic             hit;
    logic [KindW-1:0] kind;
  } kind_match_t;

  // One result word
  typedef struct packed {
    logic                write_valid;
    logic [KindW-1:0]    sentence_kind;
    logic [WIdxW-1:0]    write_index;
    logic [7:0]          write_data;
    logic                frame_done;
    logic [NumKinds-1:0] update_mask;
    logic                type_error;
  } result_t;

endpackage

[rtl/nmea_cls_in_if.sv]
interface nmea_cls_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

[rtl/nmea_cls_out_if.sv]
interface nmea_cls_out_if;
  logic                                valid;
  logic                                ready;
  logic                                write_valid;
  logic [nmea_cls_pkg::KindW-1:0]      sentence_kind;
  logic [nmea_cls_pkg::WIdxW-1:0]      write_index;
  logic [7:0]                          write_data;
  logic                                frame_done;
  logic [nmea_cls_pkg::NumKinds-1:0]   update_mask;
  logic                                type_error;

  modport source (output valid, output write_valid, output sentence_kind, output write_index,
                  output write_data, output frame_done, output update_mask,
                  output type_error, input ready);
  modport sink   (input valid, input write_valid, input sentence_kind, input write_index,
                  input write_data, input frame_done, input update_mask,
                  input type_error, output ready);
endinterface

[rtl/nmea_cls_kind_match.sv]
module nmea_cls_kind_match (
  input  logic [nmea_cls_pkg::CodeW-1:0] code_i,
  output nmea_cls_pkg::kind_match_t      match_o
);

  // Parallel compare against every table entry; codes are distinct
  always_comb begin
    match_o = '0;
    for (int k = 0; k < nmea_cls_pkg::NumKinds; k++) begin
      if (code_i == nmea_cls_pkg::KindCodes[k]) begin
        match_o.hit  = 1'b1;
        match_o.kind = nmea_cls_pkg::KindW'(k);
      end
    end
  end

endmodule

[rtl/nmea_sentence_classifier_unit.sv]
// NMEA sentence classifier.
// in_i carries one word per item: mode 0 is a received byte (rx_byte), mode 1 is
// one time tick. out_o returns exactly one result word per accepted item, in order.
// A '$' opens a sentence; after "GP" the next three bytes name the talker type,
// which is looked up in a 19-entry table. On a hit, later bytes come out as buffer writes
// (write_valid, sentence_kind, write_index, write_data). A tick that finds a
// sentence set pending and more than idle_timeout ticks of silence reports the
// collected update_mask with frame_done and clears the set.
// cfg_we_i / cfg_data_i write idle_timeout (reset value 1000); write it only
// while the block is idle.
// The result word is registered; a stalled output adds its wait.
// One item per cycle while the skid stage is empty; all decoding happens in the accept cycle,
// bounded by the talker table compare.
// An output register plus a one-word skid stage sit at the output: in_i.ready
// stays high while the receiver stalls until the skid stage fills, then drops
// until the receiver takes a word.
// Reset clears the parser to idle, empties both output stages and restores the
// timeout to its default.
module nmea_sentence_classifier_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  nmea_cls_in_if.sink                      in_i,
  nmea_cls_out_if.source                   out_o,
  input  logic                             cfg_we_i,
  input  logic [nmea_cls_pkg::TmoW-1:0]    cfg_data_i
);

  localparam int unsigned IdxW  = nmea_cls_pkg::IdxW;
  localparam int unsigned KindW = nmea_cls_pkg::KindW;
  localparam int unsigned MaskW = nmea_cls_pkg::NumKinds;
  localparam int unsigned TmoW  = nmea_cls_pkg::TmoW;

  // Parser state
  nmea_cls_pkg::phase_e phase_q, phase_d;
  logic [15:0]          code_q, code_d;
  logic [KindW-1:0]     kind_q, kind_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [MaskW-1:0]     mask_q, mask_d;
  logic                 err_q, err_d;
  logic                 pend_q, pend_d;
  logic [TmoW-1:0]      cnt_q, cnt_d;
  logic [TmoW-1:0]      tmo_q;

  // Output stages
  nmea_cls_pkg::result_t main_q, main_d, skid_q, skid_d, res;
  logic                  main_v_q, main_v_d, skid_v_q, skid_v_d;

  logic                      in_ready, acc, out_take, buf_full;
  logic [TmoW-1:0]           cnt_inc;
  nmea_cls_pkg::kind_match_t match;

  // Handshake
  assign in_ready   = !skid_v_q;
  assign in_i.ready = in_ready;
  assign acc        = in_i.valid && in_ready;
  assign out_take   = main_v_q && out_o.ready;

  // Talker table lookup on the full three-byte code
  nmea_cls_kind_match u_kind_match (
    .code_i  ({code_q, in_i.rx_byte}),
    .match_o (match)
  );

  assign cnt_inc  = (cnt_q == '1) ? cnt_q : cnt_q + TmoW'(1);
  assign buf_full = (idx_q >= IdxW'(nmea_cls_pkg::BufferSize));

  // Per-item decode: next state and result word
  always_comb begin
    phase_d = phase_q;
    code_d  = code_q;
    kind_d  = kind_q;
    idx_d   = idx_q;
    mask_d  = mask_q;
    err_d   = err_q;
    pend_d  = pend_q;
    cnt_d   = cnt_q;
    res            = '0;
    res.type_error = err_q;

    if (in_i.mode) begin
      // tick: saturating silence count, then timeout report
      cnt_d = cnt_inc;
      if (pend_q && (cnt_inc > tmo_q)) begin
        res.frame_done  = 1'b1;
        res.update_mask = mask_q;
        mask_d = '0;
        err_d  = 1'b0;
        idx_d  = '0;
        pend_d = 1'b0;
      end
    end else begin
      cnt_d = '0;
      if (!buf_full) begin
        if (in_i.rx_byte == nmea_cls_pkg::ChDollar) begin
          idx_d   = '0;
          pend_d  = 1'b1;
          phase_d = nmea_cls_pkg::PhWaitG;
        end else begin
          case (phase_q)
            nmea_cls_pkg::PhWaitG: begin
              if (in_i.rx_byte == nmea_cls_pkg::ChG) phase_d = nmea_cls_pkg::PhWaitP;
            end
            nmea_cls_pkg::PhWaitP: begin
              if (in_i.rx_byte == nmea_cls_pkg::ChP) phase_d = nmea_cls_pkg::PhCode1;
            end
            nmea_cls_pkg::PhCode1: begin
              code_d  = {in_i.rx_byte, 8'h00};
              phase_d = nmea_cls_pkg::PhCode2;
            end
            nmea_cls_pkg::PhCode2: begin
              code_d  = {code_q[15:8], in_i.rx_byte};
              phase_d = nmea_cls_pkg::PhCode3;
            end
            nmea_cls_pkg::PhCode3: begin
              if (match.hit) begin
                kind_d  = match.kind;
                mask_d  = mask_q | (MaskW'(1) << match.kind);
                phase_d = nmea_cls_pkg::PhStore;
              end else begin
                err_d          = 1'b1;
                res.type_error = 1'b1;
                phase_d        = nmea_cls_pkg::PhIdle;
              end
            end
            nmea_cls_pkg::PhStore: begin
              res.write_valid   = 1'b1;
              res.sentence_kind = kind_q;
              res.write_index   = nmea_cls_pkg::WIdxW'(idx_q);
              res.write_data    = in_i.rx_byte;
              idx_d             = idx_q + IdxW'(1);
            end
            default: begin
              phase_d = nmea_cls_pkg::PhIdle;
            end
          endcase
        end
      end
    end
  end

  // Parser state and config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nmea_cls_pkg::PhIdle;
      code_q  <= '0;
      kind_q  <= '0;
      idx_q   <= '0;
      mask_q  <= '0;
      err_q   <= 1'b0;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
      tmo_q   <= nmea_cls_pkg::TimeoutRst;
    end else begin
      if (acc) begin
        phase_q <= phase_d;
        code_q  <= code_d;
        kind_q  <= kind_d;
        idx_q   <= idx_d;
        mask_q  <= mask_d;
        err_q   <= err_d;
        pend_q  <= pend_d;
        cnt_q   <= cnt_d;
      end
      if (cfg_we_i) tmo_q <= cfg_data_i;
    end
  end

  // Output register with skid stage
  always_comb begin
    main_v_d = main_v_q;
    main_d   = main_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (out_take) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end else if (acc) begin
        main_d = res;
      end else begin
        main_v_d = 1'b0;
      end
    end else if (acc) begin
      if (main_v_q) begin
        skid_v_d = 1'b1;
        skid_d   = res;
      end else begin
        main_v_d = 1'b1;
        main_d   = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  // Result word to the port
  assign out_o.valid         = main_v_q;
  assign out_o.write_valid   = main_q.write_valid;
  assign out_o.sentence_kind = main_q.sentence_kind;
  assign out_o.write_index   = main_q.write_index;
  assign out_o.write_data    = main_q.write_data;
  assign out_o.frame_done    = main_q.frame_done;
  assign out_o.update_mask   = main_q.update_mask;
  assign out_o.type_error    = main_q.type_error;

`ifndef SYNTH
  // skid stage only fills behind a held main word
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid word held without main word");

  // a report word never carries a buffer write
  a_report_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.frame_done) |-> !out_o.write_valid)
    else $error("report word also carries a write");

  // a report clears the collected set
  a_report_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && res.frame_done) |=> (!pend_q && mask_q == '0 && !err_q && idx_q == '0))
    else $error("report left state behind");

  // write index never runs past the buffer
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IdxW'(nmea_cls_pkg::BufferSize))
    else $error("write index beyond buffer");
`endif

endmodule
